FILE: hw/rtl/sorted_list_insert_delete_assert.svh
// Assertion macros shared by the sorted list block.
`ifndef SORTED_LIST_INSERT_DELETE_ASSERT_SVH
`define SORTED_LIST_INSERT_DELETE_ASSERT_SVH
`ifndef SYNTHESIS
// Checked property with a reset that disables it.
`define SLI_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Checked property that also holds during reset.
`define SLI_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SLI_ASSERT(lbl, clk, rst, prop, msg)
`define SLI_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

FILE: hw/rtl/sli_pkg.sv
// Types and constants of the sorted list block.
package sli_pkg;

  localparam int CAPACITY = 16;
  localparam int COUNT_W  = 5;
  localparam int VALUE_W  = 32;

  typedef enum logic [1:0] {
    FUNC_INSERT = 2'd0,
    FUNC_DELETE = 2'd1,
    FUNC_READ   = 2'd2
  } func_t;

  typedef enum logic [2:0] {
    ST_INSERTED = 3'd0,
    ST_FULL     = 3'd1,
    ST_DELETED  = 3'd2,
    ST_NOTFOUND = 3'd3,
    ST_ENTRY    = 3'd4,
    ST_EMPTY    = 3'd5
  } status_t;

endpackage

FILE: hw/rtl/sli_req_if.sv
// Request channel of the sorted list block.
interface sli_req_if;
  logic                                valid;
  logic                                ready;
  logic [1:0]                          func;
  logic signed [sli_pkg::VALUE_W-1:0]  value;

  modport source (output valid, output func, output value, input ready);
  modport sink (input valid, input func, input value, output ready);
endinterface

FILE: hw/rtl/sli_rsp_if.sv
// Result channel of the sorted list block.
interface sli_rsp_if;
  logic                                valid;
  logic                                ready;
  logic signed [sli_pkg::VALUE_W-1:0]  value_out;
  sli_pkg::status_t                    status;
  logic [sli_pkg::COUNT_W-1:0]         count;
  logic                                last;

  modport source (output valid, output value_out, output status, output count,
                  output last, input ready);
  modport sink (input valid, input value_out, input status, input count,
                input last, output ready);
endinterface

FILE: hw/rtl/sli_mem.sv
// Entry table: one write port and one registered read port.
module sli_mem #(
  parameter int DEPTH = sli_pkg::CAPACITY
) (
  input  logic                                clk,
  input  logic                                rd_en,
  input  logic [$clog2(DEPTH)-1:0]            rd_addr,
  output logic signed [sli_pkg::VALUE_W-1:0]  rd_data,
  input  logic                                wr_en,
  input  logic [$clog2(DEPTH)-1:0]            wr_addr,
  input  logic signed [sli_pkg::VALUE_W-1:0]  wr_data
);

  logic signed [sli_pkg::VALUE_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: hw/rtl/sli_ctrl.sv
// Sequencer for insert, delete and read out, with the result register.
module sli_ctrl #(
  parameter int CAPACITY = sli_pkg::CAPACITY
) (
  input  logic                                clk,
  input  logic                                rst,
  sli_req_if.sink                             req,
  sli_rsp_if.source                           rsp,
  output logic                                rd_en,
  output logic [$clog2(CAPACITY)-1:0]         rd_addr,
  input  logic signed [sli_pkg::VALUE_W-1:0]  rd_data,
  output logic                                wr_en,
  output logic [$clog2(CAPACITY)-1:0]         wr_addr,
  output logic signed [sli_pkg::VALUE_W-1:0]  wr_data
);

  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

  typedef enum logic [2:0] {
    S_IDLE, S_INS_RD, S_INS_EV, S_DEL_RD, S_DEL_EV, S_RO_RD, S_RO_EV, S_EMIT
  } state_t;

  state_t                             state;
  state_t                             ret_state;
  logic [CNT_W-1:0]                   cnt;
  logic [CNT_W-1:0]                   idx;
  logic                               found;
  logic signed [sli_pkg::VALUE_W-1:0] op_value;
  logic signed [sli_pkg::VALUE_W-1:0] res_value;
  sli_pkg::status_t                   res_status;
  logic                               res_last;
  logic                               out_valid;
  logic                               out_free;
  logic                               ins_shift;

  assign req.ready = (state == S_IDLE);
  assign rsp.valid = out_valid;
  assign out_free  = !out_valid || rsp.ready;
  assign ins_shift = (op_value <= rd_data);

  // Memory accesses follow the state; a write always lands before the next read is issued.
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = IDX_W'(idx);
    wr_en   = 1'b0;
    wr_addr = IDX_W'(idx);
    wr_data = op_value;
    unique case (state)
      S_INS_RD: begin
        if (idx != '0) begin
          rd_en   = 1'b1;
          rd_addr = IDX_W'(idx - 1'b1);
        end else begin
          wr_en = 1'b1;
        end
      end
      S_INS_EV: begin
        wr_en   = 1'b1;
        wr_data = ins_shift ? rd_data : op_value;
      end
      S_DEL_RD: begin
        rd_en = (idx != cnt);
      end
      S_DEL_EV: begin
        wr_en   = found;
        wr_addr = IDX_W'(idx - 1'b1);
        wr_data = rd_data;
      end
      S_RO_RD: begin
        rd_en = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      ret_state <= S_IDLE;
      cnt       <= '0;
      idx       <= '0;
      found     <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      // The emit state reloads the result register itself when it is free.
      if (out_valid && rsp.ready && state != S_EMIT) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          res_value <= '0;
          res_last  <= 1'b1;
          ret_state <= S_IDLE;
          op_value  <= req.value;
          if (req.valid) begin
            case (req.func)
              sli_pkg::FUNC_INSERT: begin
                if (cnt == CAP_CNT) begin
                  res_status <= sli_pkg::ST_FULL;
                  state      <= S_EMIT;
                end else begin
                  idx   <= cnt;
                  state <= S_INS_RD;
                end
              end
              sli_pkg::FUNC_DELETE: begin
                idx   <= '0;
                found <= 1'b0;
                state <= S_DEL_RD;
              end
              sli_pkg::FUNC_READ: begin
                if (cnt == '0) begin
                  res_status <= sli_pkg::ST_EMPTY;
                  state      <= S_EMIT;
                end else begin
                  idx   <= '0;
                  state <= S_RO_RD;
                end
              end
              default: begin
              end
            endcase
          end
        end
        S_INS_RD: begin
          if (idx == '0) begin
            cnt        <= cnt + 1'b1;
            res_status <= sli_pkg::ST_INSERTED;
            state      <= S_EMIT;
          end else begin
            state <= S_INS_EV;
          end
        end
        S_INS_EV: begin
          if (ins_shift) begin
            idx   <= idx - 1'b1;
            state <= S_INS_RD;
          end else begin
            cnt        <= cnt + 1'b1;
            res_status <= sli_pkg::ST_INSERTED;
            state      <= S_EMIT;
          end
        end
        S_DEL_RD: begin
          if (idx == cnt) begin
            if (found) begin
              cnt        <= cnt - 1'b1;
              res_status <= sli_pkg::ST_DELETED;
            end else begin
              res_status <= sli_pkg::ST_NOTFOUND;
            end
            state <= S_EMIT;
          end else begin
            state <= S_DEL_EV;
          end
        end
        S_DEL_EV: begin
          if (!found && rd_data == op_value) begin
            found <= 1'b1;
          end
          idx   <= idx + 1'b1;
          state <= S_DEL_RD;
        end
        S_RO_RD: begin
          state <= S_RO_EV;
        end
        S_RO_EV: begin
          res_value  <= rd_data;
          res_status <= sli_pkg::ST_ENTRY;
          res_last   <= (idx + 1'b1 == cnt);
          ret_state  <= (idx + 1'b1 == cnt) ? S_IDLE : S_RO_RD;
          idx        <= idx + 1'b1;
          state      <= S_EMIT;
        end
        S_EMIT: begin
          if (out_free) begin
            out_valid     <= 1'b1;
            rsp.value_out <= res_value;
            rsp.status    <= res_status;
            rsp.count     <= (sli_pkg::COUNT_W)'(cnt);
            rsp.last      <= res_last;
            state         <= ret_state;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

FILE: hw/rtl/sorted_list_insert_delete.sv
// Top level of the sorted list block: sequencer, entry table and checks.
//
// The block holds an ascending list of signed 32-bit values, duplicates
// allowed, in a single-port-read, single-port-write table of CAPACITY
// entries. A request carries func (insert, delete first match, read out)
// and value. Insert walks the table from the top entry down, moving each
// larger-or-equal entry up by one until it finds the slot, then offers
// its result. Delete walks the whole list from the bottom, closing the
// gap behind the first match. Read out emits one result per entry (read
// issue, data return, result load), with last set on the final one; an
// empty list gives one empty result. The table read data is registered,
// so each step of a walk has a state that issues the read and a state
// that uses the data. A full table drops an insert with the full status.
// The result register lets a new request be taken while the previous
// result still waits for the sink. Requests with the unused func code
// give no result. No clearing pass follows reset: entries at or above
// the count are never read.
`include "sorted_list_insert_delete_assert.svh"
module sorted_list_insert_delete #(
  parameter int CAPACITY = sli_pkg::CAPACITY
) (
  input  logic       clk,
  input  logic       rst,
  sli_req_if.sink    req,
  sli_rsp_if.source  rsp
);

  localparam int IDX_W = $clog2(CAPACITY);

  logic                               rd_en;
  logic [IDX_W-1:0]                   rd_addr;
  logic signed [sli_pkg::VALUE_W-1:0] rd_data;
  logic                               wr_en;
  logic [IDX_W-1:0]                   wr_addr;
  logic signed [sli_pkg::VALUE_W-1:0] wr_data;
  logic                               req_known;

  // The sequencer owns the count and the result register.
  sli_ctrl #(
    .CAPACITY (CAPACITY)
  ) u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .req     (req),
    .rsp     (rsp),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  // The entry table itself.
  sli_mem #(
    .DEPTH (CAPACITY)
  ) u_mem (
    .clk     (clk),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  // A request with one of the three defined func codes.
  assign req_known = (req.func == sli_pkg::FUNC_INSERT) || (req.func == sli_pkg::FUNC_DELETE) ||
                     (req.func == sli_pkg::FUNC_READ);

  // A request that starts real work keeps the block busy on the next cycle.
  `SLI_ASSERT(a_busy_after_request, clk, rst, req.valid && req.ready && req_known |=> !req.ready, "request did not make the block busy")
  // Only read-out entries may come with more results to follow.
  `SLI_ASSERT(a_last_unless_entry, clk, rst, rsp.valid && rsp.status != sli_pkg::ST_ENTRY |-> rsp.last, "single result without last")
  // Results other than entries carry a zero value.
  `SLI_ASSERT(a_zero_value, clk, rst, rsp.valid && rsp.status != sli_pkg::ST_ENTRY |-> rsp.value_out == '0, "non-entry result with a value")
  // A freshly reset block offers no result.
  `SLI_ASSERT_ALWAYS(a_reset_idle, clk, $past(rst) && !rst |-> !rsp.valid, "result valid right after reset")

endmodule
